/* rtl/core/dtq_pkg.sv */
// shared types, codes and ordering function for the deadline timer queue
package dtq_pkg;

	localparam int MAX_FIRE = 16;
	localparam logic [62:0] T63_MAX = {63{1'b1}};
	localparam logic [19:0] MIN_DELAY_RESET = 20'd1000;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam logic [2:0] OP_HOLD   = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_CANCEL = 3'd2;
	localparam logic [2:0] OP_TICK   = 3'd3;
	localparam logic [2:0] OP_SORT   = 3'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tmr_id;
		logic [62:0] deadline;
		logic        repeat_req;
		logic [31:0] interval;
		logic [62:0] now;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        is_earliest;
		logic        fired_valid;
		logic [7:0]  fired_id;
		logic        next_valid;
		logic [62:0] next_delay;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [62:0] deadline;
		logic [7:0]  handle;
		logic [31:0] interval;
		logic        rep;
	} timer_t;

	typedef struct packed {
		logic   valid;
		timer_t t;
	} entry_t;

	typedef struct packed {
		logic [2:0]  op;
		logic        phase;
		logic        any_match;
		logic [62:0] now;
		entry_t      fresh;
	} cell_cmd_t;

	// valid entries first, then by deadline, then by lower handle
	function automatic logic orders_ahead(entry_t a, entry_t b);
		logic r;
		if (!a.valid) begin
			r = 1'b0;
		end else if (!b.valid) begin
			r = 1'b1;
		end else if (a.t.deadline != b.t.deadline) begin
			r = a.t.deadline < b.t.deadline;
		end else begin
			r = a.t.handle < b.t.handle;
		end
		return r;
	endfunction

endpackage

/* rtl/core/dtq_cell.sv */
// one timer slot of the ordered chain, with odd-even exchange against its neighbors
module dtq_cell #(
	parameter int SLOTS = 16,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dtq_pkg::cell_cmd_t cmd,
	input  dtq_pkg::entry_t    left_ent,
	input  dtq_pkg::entry_t    right_ent,
	output dtq_pkg::entry_t    ent,
	output logic               match,
	output logic               fire
);

	localparam bit HAS_LEFT = IDX > 0;
	localparam bit HAS_RIGHT = IDX < SLOTS - 1;
	localparam bit IS_LAST = IDX == SLOTS - 1;
	localparam bit CAN_FIRE = IDX < dtq_pkg::MAX_FIRE;
	localparam logic PAIR_PAR = 1'(IDX % 2);

	logic            valid_q;
	dtq_pkg::timer_t tmr_q;
	dtq_pkg::entry_t ent_d;
	logic [63:0]     rearm_sum;

	assign ent = '{valid: valid_q, t: tmr_q};
	assign match = valid_q && (tmr_q.handle == cmd.fresh.t.handle);
	assign fire = CAN_FIRE && valid_q && (tmr_q.deadline <= cmd.now);

	always_comb begin
		rearm_sum = {1'b0, cmd.now} + 64'(tmr_q.interval);
		ent_d = ent;
		unique case (cmd.op)
			dtq_pkg::OP_ADD: begin
				if (match || (!cmd.any_match && IS_LAST && !valid_q)) begin
					ent_d = cmd.fresh;
				end
			end
			dtq_pkg::OP_CANCEL: begin
				if (match) begin
					ent_d.valid = 1'b0;
				end
			end
			dtq_pkg::OP_TICK: begin
				if (fire) begin
					if (tmr_q.rep) begin
						ent_d.t.deadline = rearm_sum[63] ? dtq_pkg::T63_MAX : rearm_sum[62:0];
					end else begin
						ent_d.valid = 1'b0;
					end
				end
			end
			dtq_pkg::OP_SORT: begin
				if (cmd.phase == PAIR_PAR) begin
					if (HAS_RIGHT && dtq_pkg::orders_ahead(right_ent, ent)) begin
						ent_d = right_ent;
					end
				end else begin
					if (HAS_LEFT && dtq_pkg::orders_ahead(ent, left_ent)) begin
						ent_d = left_ent;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ent_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		tmr_q <= ent_d.t;
	end

endmodule

/* rtl/core/deadline_timer_queue.sv */
// top level of the ordered deadline timer queue: cell chain, sequencer and result stage
//
// Input channel (in_valid / in_stall / in_item) takes add, cancel and tick commands,
// one at a time; in_stall stays high from a transfer until its last result is taken.
// The SLOTS timers sit in a chain of cells kept sorted by deadline, then handle.
// Each command is first applied to the cells (write, clear or re-arm),
// then passes of odd-even exchange between neighbor cells restore the order,
// then the next delay is formed from the head cell.
// A tick that expires n timers gives n results (at most 16, or a single result when
// none expire), one per cycle while not stalled; the exchange passes of the chain
// take most of the time that an item occupies the block.
// Output channel (out_valid / out_stall / out_item) holds its result steady while
// out_stall is high; the next input is taken after the last result transfers.
// cfg_we writes min_arm_delay from cfg_data; assert it only while the block is idle (not enforced).
// Reset empties the queue and sets min_arm_delay to 1000 microseconds.
module deadline_timer_queue #(
	parameter int SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  dtq_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output dtq_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [19:0]        cfg_data
);

	localparam int FIRE_N = SLOTS < dtq_pkg::MAX_FIRE ? SLOTS : dtq_pkg::MAX_FIRE;
	localparam int NXT = FIRE_N > 1 ? 1 : 0;
	localparam int CNT_W = SLOTS > 1 ? $clog2(SLOTS) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_APPLY = 3'd1;
	localparam logic [2:0] S_SORT  = 3'd2;
	localparam logic [2:0] S_NEXT  = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [19:0]        min_delay_q;
	dtq_pkg::in_item_t  item_q;
	logic [1:0]         status_q;
	logic               early_q;
	logic               nv_q;
	logic [62:0]        nd_q;
	logic               fire_vld_q [FIRE_N];
	logic [7:0]         fire_id_q [FIRE_N];

	dtq_pkg::cell_cmd_t cmd;
	dtq_pkg::entry_t    ent_w [SLOTS];
	logic [SLOTS-1:0]   match_w;
	logic [SLOTS-1:0]   fire_w;
	logic               any_match;
	logic               full;
	logic               last_w;
	logic               xfer_out;
	logic [62:0]        diff;
	logic [62:0]        nd_d;
	logic               sorted_ok;

	assign any_match = |match_w;
	assign full = ent_w[SLOTS-1].valid && !any_match;
	assign in_stall = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign xfer_out = out_valid && !out_stall;
	assign last_w = (FIRE_N == 1) || !fire_vld_q[NXT];

	always_comb begin
		cmd.op = dtq_pkg::OP_HOLD;
		cmd.phase = cnt_q[0];
		cmd.any_match = any_match;
		cmd.now = item_q.now;
		cmd.fresh.valid = 1'b1;
		cmd.fresh.t.deadline = item_q.deadline;
		cmd.fresh.t.handle = item_q.tmr_id;
		cmd.fresh.t.interval = item_q.interval;
		cmd.fresh.t.rep = item_q.repeat_req;
		if (state_q == S_APPLY) begin
			unique case (item_q.kind)
				dtq_pkg::KIND_ADD:    cmd.op = dtq_pkg::OP_ADD;
				dtq_pkg::KIND_CANCEL: cmd.op = dtq_pkg::OP_CANCEL;
				dtq_pkg::KIND_TICK:   cmd.op = dtq_pkg::OP_TICK;
				default:              cmd.op = dtq_pkg::OP_HOLD;
			endcase
		end else if (state_q == S_SORT) begin
			cmd.op = dtq_pkg::OP_SORT;
		end
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		dtq_pkg::entry_t left_ent;
		dtq_pkg::entry_t right_ent;
		if (i > 0) begin : g_l
			assign left_ent = ent_w[i-1];
		end else begin : g_l0
			assign left_ent = '0;
		end
		if (i < SLOTS - 1) begin : g_r
			assign right_ent = ent_w[i+1];
		end else begin : g_r0
			assign right_ent = '0;
		end
		dtq_cell #(
			.SLOTS(SLOTS),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.left_ent(left_ent),
			.right_ent(right_ent),
			.ent(ent_w[i]),
			.match(match_w[i]),
			.fire(fire_w[i])
		);
	end

	// delay to the head deadline, floored at the configured minimum
	always_comb begin
		diff = (ent_w[0].t.deadline > item_q.now) ? ent_w[0].t.deadline - item_q.now : '0;
		nd_d = (diff < 63'(min_delay_q)) ? 63'(min_delay_q) : diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			min_delay_q <= dtq_pkg::MIN_DELAY_RESET;
		end else begin
			if (cfg_we) begin
				min_delay_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					cnt_q <= '0;
					state_q <= S_SORT;
				end
				S_SORT: begin
					if (cnt_q == CNT_W'(SLOTS - 1)) begin
						state_q <= S_NEXT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_NEXT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (xfer_out && last_w) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			item_q <= in_item;
		end
		if (state_q == S_APPLY) begin
			if (item_q.kind == dtq_pkg::KIND_ADD && full) begin
				status_q <= dtq_pkg::ST_FULL;
			end else if (item_q.kind == dtq_pkg::KIND_CANCEL && !any_match) begin
				status_q <= dtq_pkg::ST_NOT_FOUND;
			end else begin
				status_q <= dtq_pkg::ST_OK;
			end
			for (int k = 0; k < FIRE_N; k++) begin
				fire_vld_q[k] <= (item_q.kind == dtq_pkg::KIND_TICK) && fire_w[k];
				fire_id_q[k] <= ((item_q.kind == dtq_pkg::KIND_TICK) && fire_w[k]) ?
					ent_w[k].t.handle : 8'd0;
			end
		end
		if (state_q == S_NEXT) begin
			nv_q <= ent_w[0].valid;
			nd_q <= ent_w[0].valid ? nd_d : '0;
			early_q <= (item_q.kind == dtq_pkg::KIND_ADD) && (status_q == dtq_pkg::ST_OK) &&
				ent_w[0].valid && (ent_w[0].t.deadline == item_q.deadline);
		end
		if (xfer_out) begin
			for (int k = 0; k < FIRE_N - 1; k++) begin
				fire_vld_q[k] <= fire_vld_q[k+1];
				fire_id_q[k] <= fire_id_q[k+1];
			end
			fire_vld_q[FIRE_N-1] <= 1'b0;
			fire_id_q[FIRE_N-1] <= 8'd0;
		end
	end

	always_comb begin
		out_item.status = status_q;
		out_item.is_earliest = early_q;
		out_item.fired_valid = fire_vld_q[0];
		out_item.fired_id = fire_id_q[0];
		out_item.next_valid = nv_q;
		out_item.next_delay = nd_q;
		out_item.last = last_w;
	end

	always_comb begin
		sorted_ok = 1'b1;
		for (int i = 0; i < SLOTS - 1; i++) begin
			if (dtq_pkg::orders_ahead(ent_w[i+1], ent_w[i])) begin
				sorted_ok = 1'b0;
			end
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while results pending");

	a_chain_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sorted_ok)
		else $error("cell chain out of order after exchange passes");

	a_quiet_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.fired_valid |-> out_item.last)
		else $error("non-fire result not marked last");

endmodule
